@@ rtl/ibe_pkg.sv @@
// Shared types and constants for the ingress bandwidth estimator
`timescale 1ns / 1ps
package ibe_pkg;

    localparam int WINDOW_BYTES_BITS_DEF = 48;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_RATE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF   = CFG_INDEX_W'(1);

    localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
    localparam logic [31:0] HOLDOFF_RESET = 32'd250000000;

    localparam int RISE_SHIFT = 2;
    localparam int FALL_SHIFT = 8;
    localparam int DIV_STEPS  = 64;

    typedef struct packed {
        logic [15:0] packet_len;
        logic [62:0] arrival_time_ns;
        logic [62:0] current_rate_bps;
    } in_item_t;

    typedef struct packed {
        logic               window_closed;
        logic               reconfigure;
        logic signed [63:0] rate_delta_bps;
        logic        [63:0] target_rate_bps;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic step_gap;
        logic step_avg;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic sat_chk;
        logic div_step;
        logic close_win;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic closed;
        logic span_pos;
        logic sat;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/ibe_ctrl.sv @@
// Sequencer for the estimator: steps one arrival through the datapath
`timescale 1ns / 1ps
module ibe_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output ibe_pkg::cmd_t  cmd,
    input  ibe_pkg::sts_t  sts
);
    import ibe_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP,
        ST_AVG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_SAT,
        ST_DIV,
        ST_PEAK,
        ST_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_GAP;
                end
            end
            ST_GAP: begin
                cmd.step_gap = 1'b1;
                state_next   = ST_AVG;
            end
            ST_AVG: begin
                cmd.step_avg = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.mul_sum = 1'b1;
                state_next  = ST_SAT;
            end
            ST_SAT: begin
                cmd.sat_chk = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK: begin
                cmd.close_win = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // branch on the close decision and on rate saturation
        if (state_reg == ST_AVG) begin
            if (sts.closed && sts.span_pos) begin
                state_next = ST_MUL_LO;
            end else if (sts.closed) begin
                state_next = ST_PEAK;
            end
        end
        if (state_reg == ST_SAT && sts.sat) begin
            state_next = ST_PEAK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

@@ rtl/ibe_dpath.sv @@
// Datapath: gap average, window bytes, byte-rate divider, peak average, result register
`timescale 1ns / 1ps
module ibe_dpath #(
    parameter int WINDOW_BYTES_BITS = ibe_pkg::WINDOW_BYTES_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ibe_pkg::cmd_t                    cmd,
    output ibe_pkg::sts_t                    sts,
    input  ibe_pkg::in_item_t                s_data,
    input  logic                             cfg_wr,
    input  logic [ibe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ibe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             m_ready,
    output logic                             m_valid,
    output ibe_pkg::out_item_t               m_data
);
    import ibe_pkg::*;

    localparam int W = WINDOW_BYTES_BITS;
    localparam logic [W-1:0] WMAX = '1;

    // input hold
    logic [15:0] len_reg;
    logic [62:0] now_reg;
    logic [62:0] cur_reg;

    // architectural state
    logic [62:0] last_reg;
    logic [29:0] avg_reg;
    logic [62:0] wstart_reg;
    logic [W-1:0] wbytes_reg;
    logic [63:0] peak_reg;
    logic [31:0] holdoff_reg;

    // per-item working registers
    logic [29:0] gap_reg;
    logic        closed_reg;
    logic        span_pos_reg;
    logic [62:0] span_reg;
    logic [61:0] plo_reg;
    logic [61:0] phi_reg;
    logic [63:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [63:0] quo_reg;
    logic        sat_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;

    // window byte accumulation
    logic [W:0]  wsum;
    logic [W-1:0] wbytes_next;
    assign wsum        = {1'b0, wbytes_reg} + (W+1)'(len_reg);
    assign wbytes_next = wsum[W] ? WMAX : wsum[W-1:0];

    // capped inter-arrival gap
    logic [62:0] gap_diff;
    logic [29:0] gap_next;
    assign gap_diff = now_reg - last_reg;
    always_comb begin
        if (now_reg < last_reg || gap_diff > 63'(NS_PER_SEC)) begin
            gap_next = NS_PER_SEC;
        end else begin
            gap_next = gap_diff[29:0];
        end
    end

    // gap average
    logic        avg_rise;
    logic [30:0] avg_sum;
    logic [29:0] avg_next;
    assign avg_rise = gap_reg > avg_reg;
    always_comb begin
        if (avg_rise) begin
            avg_sum = 31'(avg_reg) - 31'(avg_reg >> RISE_SHIFT) + 31'(gap_reg >> RISE_SHIFT);
        end else begin
            avg_sum = 31'(avg_reg) - 31'(avg_reg >> FALL_SHIFT) + 31'(gap_reg >> FALL_SHIFT);
        end
    end
    assign avg_next = avg_sum[29:0];

    // shared 32x30 multiplier for bytes * 1e9
    logic [63:0] bytes64;
    logic [31:0] mul_op;
    logic [61:0] mul_res;
    assign bytes64 = 64'(wbytes_reg);
    assign mul_op  = cmd.mul_hi ? bytes64[63:32] : bytes64[31:0];
    assign mul_res = 62'(mul_op) * 62'(NS_PER_SEC);

    logic [95:0] prod;
    assign prod = 96'({phi_reg, 32'b0}) + 96'(plo_reg);

    // one restoring divide step
    logic [63:0] trial;
    logic        trial_ge;
    assign trial    = {rem_reg[62:0], dvd_reg[63]};
    assign trial_ge = trial >= {1'b0, span_reg};

    // peak average
    logic [63:0] rate;
    logic [63:0] peak_next;
    assign rate = sat_reg ? '1 : quo_reg;
    always_comb begin
        if (rate > peak_reg) begin
            peak_next = peak_reg - (peak_reg >> RISE_SHIFT) + (rate >> RISE_SHIFT);
        end else begin
            peak_next = peak_reg - (peak_reg >> FALL_SHIFT) + (rate >> FALL_SHIFT);
        end
    end

    // result
    logic [63:0] peak15;
    logic [63:0] target;
    logic        reconf;
    assign peak15 = (peak_reg << 4) - peak_reg;
    assign target = {1'b0, peak15[63:4], 3'b000};
    assign reconf = closed_reg && (now_reg > 63'(holdoff_reg)) && (peak_reg != '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            len_reg <= s_data.packet_len;
            now_reg <= s_data.arrival_time_ns;
            cur_reg <= s_data.current_rate_bps;
        end
        if (cmd.step_gap) begin
            gap_reg <= gap_next;
        end
        if (cmd.step_avg) begin
            closed_reg   <= gap_reg > avg_next;
            span_pos_reg <= now_reg > wstart_reg;
            span_reg     <= now_reg - wstart_reg;
        end
        if (cmd.mul_lo) begin
            plo_reg <= mul_res;
        end
        if (cmd.mul_hi) begin
            phi_reg <= mul_res;
        end
        if (cmd.mul_sum) begin
            rem_reg <= 64'(prod[95:64]);
            dvd_reg <= prod[63:0];
            quo_reg <= '0;
        end
        if (cmd.sat_chk) begin
            sat_reg <= rem_reg >= {1'b0, span_reg};
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial - {1'b0, span_reg} : trial;
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[62:0], trial_ge};
        end
        if (cmd.load_out) begin
            m_data_reg.window_closed   <= closed_reg;
            m_data_reg.reconfigure     <= reconf;
            m_data_reg.rate_delta_bps  <= reconf ? signed'(target - {1'b0, cur_reg}) : '0;
            m_data_reg.target_rate_bps <= target;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= '0;
            avg_reg     <= '0;
            wstart_reg  <= '0;
            wbytes_reg  <= '0;
            peak_reg    <= '0;
            holdoff_reg <= HOLDOFF_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index)
                    CFG_SEED_RATE: peak_reg    <= 64'(cfg_data >> 3);
                    CFG_HOLDOFF:   holdoff_reg <= cfg_data[31:0];
                    default:       ;
                endcase
            end
            if (cmd.step_gap) begin
                wbytes_reg <= wbytes_next;
            end
            if (cmd.step_avg) begin
                avg_reg  <= avg_next;
                last_reg <= now_reg;
            end
            if (cmd.close_win) begin
                if (span_pos_reg) begin
                    peak_reg <= peak_next;
                end
                wbytes_reg <= '0;
                wstart_reg <= now_reg;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.closed   = gap_reg > avg_next;
    assign sts.span_pos = now_reg > wstart_reg;
    assign sts.sat      = rem_reg >= {1'b0, span_reg};
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/ingress_bandwidth_estimator.sv @@
// Top level of the ingress bandwidth estimator
`timescale 1ns / 1ps
// Takes one packet arrival at a time and returns exactly one result for it.
// The result is loaded into the output register after the gap and average
// steps when the window stays open. When the arrival closes the window, the
// peak-average step follows if the window span is zero or negative; if the
// byte rate saturates, the multiply, sum and saturation-check steps come
// first; otherwise the bit-serial 64-step restoring divider also runs, which
// forms bytes * 1e9 / span one quotient bit per cycle. The next arrival is
// taken in the cycle after the result is loaded. The result sits in an output
// register, so the next arrival is taken while it waits; a further arrival
// is held off until that result has been transferred. Configuration writes
// are taken in any cycle and must only be issued while the block is idle;
// writing the seed rate reloads the peak average at once.
module ingress_bandwidth_estimator #(
    parameter int WINDOW_BYTES_BITS = ibe_pkg::WINDOW_BYTES_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ibe_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ibe_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ibe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ibe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ibe_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ibe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ibe_dpath #(
        .WINDOW_BYTES_BITS (WINDOW_BYTES_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    a_reconf_needs_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window_closed || !m_data.reconfigure))
        else $error("reconfigure without a closed window");

    a_delta_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.reconfigure) |-> (m_data.rate_delta_bps == '0))
        else $error("rate delta nonzero without reconfigure");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer taken while an arrival is in progress");

endmodule
